/* rtl/core/sss_pkg.sv */
// Shared constants, payload types and register codes of the scaled sprite pixel sampler.
`default_nettype none

package sss_pkg;

	// world scale is a power of two: the texel index is a shift of the scaled offset
	localparam int WORLD_SCALE_LOG2 = 5;
	localparam int WORLD_SCALE      = 1 << WORLD_SCALE_LOG2;
	localparam int SCREEN_W         = 1024;
	localparam int SCREEN_H         = 768;
	localparam int SPRITE_MAX       = 64;

	localparam int PIX_W    = 10;
	localparam int POS_W    = 13;
	localparam int SIZE_W   = 7;
	localparam int PPU_W    = 8;
	localparam int COLOR_W  = 32;
	localparam int TEXEL_IW = 6;

	localparam int SPRITE_AW   = $clog2(SPRITE_MAX);
	localparam int TEXEL_DEPTH = SPRITE_MAX * SPRITE_MAX;
	localparam int TEXEL_AW    = $clog2(TEXEL_DEPTH);
	localparam int SCR_MAX     = (SCREEN_W > SCREEN_H) ? SCREEN_W : SCREEN_H;
	localparam int SCR_CMP_W   = $clog2(SCR_MAX + 1);
	localparam int EXT_W       = $clog2(SPRITE_MAX * WORLD_SCALE + 1);
	localparam int DIFF_W      = POS_W + 1;
	localparam int PROD_W      = EXT_W + PPU_W;
	localparam int DIV_CNT_W   = $clog2(EXT_W + 1);

	localparam int SIZE_RESET = 64;
	localparam int PPU_RESET  = 32;
	localparam int SIZE_RESET_SAT = (SIZE_RESET > SPRITE_MAX) ? SPRITE_MAX : SIZE_RESET;
	localparam int EXT_RESET  = (SIZE_RESET_SAT * WORLD_SCALE) / PPU_RESET;

	localparam int APB_DW = 32;
	localparam int APB_AW = 5;

	typedef enum logic [APB_AW-3:0] {
		REG_POS_X     = 3'd0,
		REG_POS_Y     = 3'd1,
		REG_SPR_W     = 3'd2,
		REG_SPR_H     = 3'd3,
		REG_PPU       = 3'd4,
		REG_KEY_COLOR = 3'd5
	} reg_idx_t;

	typedef enum logic {
		KIND_LOAD  = 1'b0,
		KIND_QUERY = 1'b1
	} item_kind_t;

	typedef struct packed {
		logic                kind;
		logic [TEXEL_IW-1:0] texel_row;
		logic [TEXEL_IW-1:0] texel_col;
		logic [COLOR_W-1:0]  texel_color;
		logic [PIX_W-1:0]    pixel_x;
		logic [PIX_W-1:0]    pixel_y;
	} sss_in_t;

	typedef struct packed {
		logic               write_enable;
		logic [PIX_W-1:0]   out_x;
		logic [PIX_W-1:0]   out_y;
		logic [COLOR_W-1:0] out_color;
	} sss_out_t;

	// settled configuration handed from the register block to the datapath
	typedef struct packed {
		logic signed [POS_W-1:0] pos_x;
		logic signed [POS_W-1:0] pos_y;
		logic [EXT_W-1:0]        ext_w;
		logic [EXT_W-1:0]        ext_h;
		logic [PPU_W-1:0]        ppu;
		logic [COLOR_W-1:0]      key_color;
		logic                    busy;
	} sss_cfg_t;

endpackage

`default_nettype wire

/* rtl/core/sss_div.sv */
// Restoring divider, one quotient bit per cycle, for the scaled draw extent.
`default_nettype none

module sss_div
	import sss_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [EXT_W-1:0] dividend,
	input  wire logic [PPU_W-1:0] divisor,
	output logic                  busy,
	output logic [EXT_W-1:0]      quotient
);

	logic [PPU_W-1:0]     rem_q;
	logic [EXT_W-1:0]     dvd_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic [EXT_W-1:0]     quo_q;

	logic [PPU_W:0]       trial;
	logic                 ge;
	logic [PPU_W-1:0]     rem_n;
	logic [EXT_W-1:0]     dvd_n;

	always_comb begin
		trial = {rem_q, dvd_q[EXT_W-1]};
		ge    = trial >= {1'b0, divisor};
		rem_n = ge ? PPU_W'(trial - {1'b0, divisor}) : trial[PPU_W-1:0];
		dvd_n = {dvd_q[EXT_W-2:0], ge};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			quo_q  <= EXT_W'(EXT_RESET);
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= DIV_CNT_W'(EXT_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == DIV_CNT_W'(1)) begin
				busy_q <= 1'b0;
				quo_q  <= dvd_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvd_q <= dividend;
		end else if (busy_q) begin
			rem_q <= rem_n;
			dvd_q <= dvd_n;
		end
	end

	assign busy     = busy_q;
	assign quotient = quo_q;

endmodule

`default_nettype wire

/* rtl/core/sss_cfg.sv */
// APB register block and draw extent computation.
`default_nettype none

module sss_cfg
	import sss_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [APB_AW-1:0] paddr,
	input  wire logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0]      prdata,
	output logic                   pready,
	output sss_cfg_t               cfg
);

	logic signed [POS_W-1:0] pos_x_q;
	logic signed [POS_W-1:0] pos_y_q;
	logic [SIZE_W-1:0]       spr_w_q;
	logic [SIZE_W-1:0]       spr_h_q;
	logic [PPU_W-1:0]        ppu_q;
	logic [COLOR_W-1:0]      key_q;
	logic                    pend_q;

	reg_idx_t                idx;
	logic                    wr;
	logic [PPU_W-1:0]        ppu_eff;
	logic [SIZE_W-1:0]       w_sat;
	logic [SIZE_W-1:0]       h_sat;
	logic [EXT_W-1:0]        dvd_w;
	logic [EXT_W-1:0]        dvd_h;
	logic                    busy_w;
	logic                    busy_h;
	logic [EXT_W-1:0]        ext_w;
	logic [EXT_W-1:0]        ext_h;

	assign idx    = reg_idx_t'(paddr[APB_AW-1:2]);
	assign wr     = psel && penable && pwrite && pready;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_x_q <= '0;
			pos_y_q <= '0;
			spr_w_q <= SIZE_W'(SIZE_RESET);
			spr_h_q <= SIZE_W'(SIZE_RESET);
			ppu_q   <= PPU_W'(PPU_RESET);
			key_q   <= '0;
			pend_q  <= 1'b0;
		end else begin
			pend_q <= wr;
			if (wr) begin
				case (idx)
					REG_POS_X:     pos_x_q <= pwdata[POS_W-1:0];
					REG_POS_Y:     pos_y_q <= pwdata[POS_W-1:0];
					REG_SPR_W:     spr_w_q <= pwdata[SIZE_W-1:0];
					REG_SPR_H:     spr_h_q <= pwdata[SIZE_W-1:0];
					REG_PPU:       ppu_q   <= pwdata[PPU_W-1:0];
					REG_KEY_COLOR: key_q   <= pwdata[COLOR_W-1:0];
					default:       ;
				endcase
			end
		end
	end

	always_comb begin
		case (idx)
			REG_POS_X:     prdata = APB_DW'($unsigned(pos_x_q));
			REG_POS_Y:     prdata = APB_DW'($unsigned(pos_y_q));
			REG_SPR_W:     prdata = APB_DW'(spr_w_q);
			REG_SPR_H:     prdata = APB_DW'(spr_h_q);
			REG_PPU:       prdata = APB_DW'(ppu_q);
			REG_KEY_COLOR: prdata = APB_DW'(key_q);
			default:       prdata = '0;
		endcase
	end

	// zero scale acts as one, oversized sprite clamps to the store size
	always_comb begin
		ppu_eff = (ppu_q == '0) ? PPU_W'(1) : ppu_q;
		w_sat   = (32'(spr_w_q) > SPRITE_MAX) ? SIZE_W'(SPRITE_MAX) : spr_w_q;
		h_sat   = (32'(spr_h_q) > SPRITE_MAX) ? SIZE_W'(SPRITE_MAX) : spr_h_q;
		dvd_w   = EXT_W'(w_sat) << WORLD_SCALE_LOG2;
		dvd_h   = EXT_W'(h_sat) << WORLD_SCALE_LOG2;
	end

	// recompute both extents after every register write
	sss_div u_div_w (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (pend_q),
		.dividend (dvd_w),
		.divisor  (ppu_eff),
		.busy     (busy_w),
		.quotient (ext_w)
	);

	sss_div u_div_h (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (pend_q),
		.dividend (dvd_h),
		.divisor  (ppu_eff),
		.busy     (busy_h),
		.quotient (ext_h)
	);

	always_comb begin
		cfg.pos_x     = pos_x_q;
		cfg.pos_y     = pos_y_q;
		cfg.ext_w     = ext_w;
		cfg.ext_h     = ext_h;
		cfg.ppu       = ppu_eff;
		cfg.key_color = key_q;
		cfg.busy      = pend_q || busy_w || busy_h;
	end

endmodule

`default_nettype wire

/* rtl/core/sss_axis.sv */
// Per-axis coverage test and nearest source texel index.
`default_nettype none

module sss_axis
	import sss_pkg::*;
(
	input  wire logic [PIX_W-1:0]       p,
	input  wire logic signed [POS_W-1:0] origin,
	input  wire logic [EXT_W-1:0]       ext,
	input  wire logic [PPU_W-1:0]       ppu,
	input  wire logic [SCR_CMP_W-1:0]   limit,
	output logic                        hit,
	output logic [SPRITE_AW-1:0]        idx
);

	logic signed [DIFF_W-1:0] d;
	logic                     on_screen;
	logic [PROD_W-1:0]        prod;
	logic [PROD_W-1:0]        scaled;

	always_comb begin
		d         = $signed({{(DIFF_W-PIX_W){1'b0}}, p}) - DIFF_W'(origin);
		on_screen = SCR_CMP_W'(p) < limit;
		hit       = on_screen && !d[DIFF_W-1] && (d[DIFF_W-2:0] < (DIFF_W-1)'(ext));
		// offset is below the extent whenever hit, so its low bits suffice
		prod      = PROD_W'(d[EXT_W-1:0]) * PROD_W'(ppu);
		scaled    = prod >> WORLD_SCALE_LOG2;
		idx       = (scaled >= PROD_W'(SPRITE_MAX)) ? SPRITE_AW'(SPRITE_MAX - 1)
		                                           : scaled[SPRITE_AW-1:0];
	end

endmodule

`default_nettype wire

/* rtl/core/scaled_sprite_pixel_sampler.sv */
// Top level of the scaled sprite pixel sampler: texel store and three-stage datapath.
//
// Channels: item (valid/ready) carries load beats (kind 0: store texel_color at
// texel_row, texel_col) and query beats (kind 1: sample screen pixel pixel_x,
// pixel_y). Every beat yields exactly one result beat on result (valid/ready),
// in order. A query result has write_enable set when the pixel falls inside the
// sprite's scaled, clipped rectangle and the nearest texel is not key_color.
// An item passes stage 1, stage 2 and the output register; throughput is one beat
// per cycle while results are taken and no recompute runs, set by the texel store
// read and one small multiply per axis. Three stage registers let the input keep
// accepting while a result waits; a stalled receiver fills them, then item_ready
// drops. Configuration goes over the APB port. After every register write the draw
// extents are recomputed by a bit-serial divider, during which item_ready is low.
// Reset clears the registers to their defaults and empties the pipeline; the
// texel store is not cleared and must be loaded before it is sampled.
`default_nettype none

module scaled_sprite_pixel_sampler
	import sss_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              item_valid,
	output logic                   item_ready,
	input  wire sss_in_t           item,
	output logic                   result_valid,
	input  wire logic              result_ready,
	output sss_out_t               result,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [APB_AW-1:0] paddr,
	input  wire logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0]      prdata,
	output logic                   pready
);

	sss_cfg_t                cfg;

	logic                    valid_s1;
	sss_in_t                 item_s1;
	logic                    valid_s2;
	logic                    hit_s2;
	logic [PIX_W-1:0]        x_s2;
	logic [PIX_W-1:0]        y_s2;
	logic [COLOR_W-1:0]      rdata_s2;
	logic                    out_valid_q;
	sss_out_t                out_q;

	logic [COLOR_W-1:0]      texel_mem [TEXEL_DEPTH];

	logic                    out_free;
	logic                    s2_free;
	logic                    s1_free;
	logic                    adv1;
	logic                    adv2;
	logic                    in_fire;
	logic                    hit_x;
	logic                    hit_y;
	logic [SPRITE_AW-1:0]    idx_x;
	logic [SPRITE_AW-1:0]    idx_y;
	logic                    hit_s1;
	logic                    load_ok;
	logic [TEXEL_AW-1:0]     waddr;
	logic [TEXEL_AW-1:0]     raddr;
	logic                    we_s2;

	sss_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// each stage moves when the one after it is empty or moving
	always_comb begin
		out_free   = !out_valid_q || result_ready;
		s2_free    = !valid_s2 || out_free;
		s1_free    = !valid_s1 || s2_free;
		adv1       = valid_s1 && s2_free;
		adv2       = valid_s2 && out_free;
		item_ready = s1_free && !cfg.busy;
		in_fire    = item_valid && item_ready;
	end

	// stage 1: input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (adv1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			item_s1 <= item;
		end
	end

	sss_axis u_axis_x (
		.p      (item_s1.pixel_x),
		.origin (cfg.pos_x),
		.ext    (cfg.ext_w),
		.ppu    (cfg.ppu),
		.limit  (SCR_CMP_W'(SCREEN_W)),
		.hit    (hit_x),
		.idx    (idx_x)
	);

	sss_axis u_axis_y (
		.p      (item_s1.pixel_y),
		.origin (cfg.pos_y),
		.ext    (cfg.ext_h),
		.ppu    (cfg.ppu),
		.limit  (SCR_CMP_W'(SCREEN_H)),
		.hit    (hit_y),
		.idx    (idx_y)
	);

	always_comb begin
		hit_s1  = (item_s1.kind == KIND_QUERY) && hit_x && hit_y;
		load_ok = (item_s1.kind == KIND_LOAD)
		       && (32'(item_s1.texel_row) < SPRITE_MAX)
		       && (32'(item_s1.texel_col) < SPRITE_MAX);
		waddr   = TEXEL_AW'(32'(item_s1.texel_row) * SPRITE_MAX + 32'(item_s1.texel_col));
		raddr   = TEXEL_AW'(32'(idx_y) * SPRITE_MAX + 32'(idx_x));
	end

	// texel store: write a load beat, read for a query, both as stage 1 moves on
	always_ff @(posedge clk) begin
		if (adv1) begin
			if (load_ok) begin
				texel_mem[waddr] <= item_s1.texel_color;
			end
			rdata_s2 <= texel_mem[raddr];
		end
	end

	// stage 2
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			hit_s2 <= hit_s1;
			x_s2   <= item_s1.pixel_x;
			y_s2   <= item_s1.pixel_y;
		end
	end

	assign we_s2 = hit_s2 && (rdata_s2 != cfg.key_color);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv2) begin
			out_q.write_enable <= we_s2;
			out_q.out_x        <= x_s2;
			out_q.out_y        <= y_s2;
			out_q.out_color    <= we_s2 ? rdata_s2 : '0;
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

	a_dark_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.write_enable |-> result.out_color == '0)
		else $error("result without write enable carries a color");

	a_key_never_drawn: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.write_enable |-> result.out_color != cfg.key_color)
		else $error("key color written");

	a_busy_blocks_items: assert property (@(posedge clk) disable iff (!arst_n)
		cfg.busy |-> !item_ready)
		else $error("item accepted while extents are recomputed");

	a_read_held_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !out_free |=> valid_s2 && (rdata_s2 === $past(rdata_s2)))
		else $error("texel read data lost under stall");

endmodule

`default_nettype wire

/* tb/sv/testbench.sv */
// Testbench for the scaled sprite pixel sampler: directed and random beats against a predictor.
`timescale 1ns / 1ps

module testbench;
	import sss_pkg::*;

	localparam int CYCLE_LIMIT = 500000;
	localparam int PHASES      = 8;
	localparam int PHASE_BEATS = 66;

	// register slots past the last defined one; writes there must change nothing
	localparam logic [APB_AW-3:0] REG_UNMAPPED_LO = 3'd6;
	localparam logic [APB_AW-3:0] REG_UNMAPPED_HI = 3'd7;

	typedef enum logic [1:0] {RX_OPEN, RX_RANDOM, RX_BURSTY} rx_mode_t;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              item_valid;
	logic              item_ready;
	sss_in_t           item;
	logic              result_valid;
	logic              result_ready;
	sss_out_t          result;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata;
	logic [APB_DW-1:0] prdata;
	logic              pready;

	// predictor copy of the configuration and the texel store
	logic signed [POS_W-1:0] cfg_pos_x;
	logic signed [POS_W-1:0] cfg_pos_y;
	logic [SIZE_W-1:0]       cfg_w;
	logic [SIZE_W-1:0]       cfg_h;
	logic [PPU_W-1:0]        cfg_ppu;
	logic [COLOR_W-1:0]      cfg_key;
	logic [COLOR_W-1:0]      texels [TEXEL_DEPTH];
	bit                      texel_loaded [TEXEL_DEPTH];

	sss_out_t pending_pixels[$];
	int       errors;
	int       cycle_count;
	bit       gaps_on;
	int       burst_left;
	rx_mode_t rx_mode;
	int       rx_run;

	scaled_sprite_pixel_sampler dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic int eff_ppu();
		return (cfg_ppu == '0) ? 1 : int'(cfg_ppu);
	endfunction

	function automatic int draw_extent(input int size);
		int s;
		s = (size > SPRITE_MAX) ? SPRITE_MAX : size;
		return s * WORLD_SCALE / eff_ppu();
	endfunction

	// source texel index along one axis, -1 when the pixel misses the sprite
	function automatic int source_index(input int pix, input int origin, input int size,
			input int screen);
		int offset, idx;
		offset = pix - origin;
		if (pix >= screen || offset < 0 || offset >= draw_extent(size))
			return -1;
		idx = offset * eff_ppu() / WORLD_SCALE;
		return (idx >= SPRITE_MAX) ? SPRITE_MAX - 1 : idx;
	endfunction

	function automatic sss_out_t render_beat(input sss_in_t beat);
		sss_out_t px;
		int sx, sy, addr;
		px = '0;
		px.out_x = beat.pixel_x;
		px.out_y = beat.pixel_y;
		if (beat.kind == KIND_LOAD) begin
			addr = int'({beat.texel_row, beat.texel_col});
			texels[addr] = beat.texel_color;
			texel_loaded[addr] = 1'b1;
		end else begin
			sx = source_index(beat.pixel_x, cfg_pos_x, cfg_w, SCREEN_W);
			sy = source_index(beat.pixel_y, cfg_pos_y, cfg_h, SCREEN_H);
			if (sx >= 0 && sy >= 0) begin
				addr = sy * SPRITE_MAX + sx;
				if (texels[addr] != cfg_key) begin
					px.write_enable = 1'b1;
					px.out_color = texels[addr];
				end
			end
		end
		return px;
	endfunction

	function automatic sss_in_t noise_beat();
		sss_in_t beat;
		beat.kind        = KIND_QUERY;
		beat.texel_row   = TEXEL_IW'($urandom_range(0, SPRITE_MAX - 1));
		beat.texel_col   = TEXEL_IW'($urandom_range(0, SPRITE_MAX - 1));
		beat.texel_color = $urandom();
		beat.pixel_x     = PIX_W'($urandom_range(0, 1023));
		beat.pixel_y     = PIX_W'($urandom_range(0, 1023));
		return beat;
	endfunction

	function automatic logic [APB_DW-1:0] pos_word(input int v);
		return 32'(v) & 32'h1FFF;
	endfunction

	// pick a pixel inside the drawn span of one axis, anywhere on screen if it is empty
	function automatic int pick_on_axis(input int origin, input int ext, input int last);
		int lo, hi;
		lo = (origin < 0) ? 0 : origin;
		hi = origin + ext - 1;
		if (hi > last)
			hi = last;
		if (ext > 0 && lo <= hi)
			return $urandom_range(lo, hi);
		return $urandom_range(0, last);
	endfunction

	task automatic send_item(input sss_in_t beat);
		if (gaps_on) begin
			if (burst_left == 0) begin
				item_valid <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
				burst_left = $urandom_range(1, 24);
			end
			burst_left--;
		end
		item <= beat;
		item_valid <= 1'b1;
		do @(posedge clk); while (!item_ready);
		pending_pixels.push_back(render_beat(beat));
	endtask

	task automatic load_texel(input int row, input int col, input logic [COLOR_W-1:0] color);
		sss_in_t beat;
		beat = noise_beat();
		beat.kind        = KIND_LOAD;
		beat.texel_row   = TEXEL_IW'(row);
		beat.texel_col   = TEXEL_IW'(col);
		beat.texel_color = color;
		send_item(beat);
	endtask

	// load the sampled texel first if it was never written
	task automatic query_pixel(input int x, input int y);
		sss_in_t beat;
		int sx, sy;
		sx = source_index(x, cfg_pos_x, cfg_w, SCREEN_W);
		sy = source_index(y, cfg_pos_y, cfg_h, SCREEN_H);
		if (sx >= 0 && sy >= 0 && !texel_loaded[sy * SPRITE_MAX + sx])
			load_texel(sy, sx, ($urandom_range(0, 6) == 0) ? cfg_key : $urandom());
		beat = noise_beat();
		beat.kind    = KIND_QUERY;
		beat.pixel_x = PIX_W'(x);
		beat.pixel_y = PIX_W'(y);
		send_item(beat);
	endtask

	task automatic apb_write(input logic [APB_AW-3:0] idx, input logic [APB_DW-1:0] value);
		// drain the pipeline before touching the configuration
		item_valid <= 1'b0;
		while (pending_pixels.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		psel    <= 1'b1;
		pwrite  <= 1'b1;
		penable <= 1'b0;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			REG_POS_X:     cfg_pos_x = value[POS_W-1:0];
			REG_POS_Y:     cfg_pos_y = value[POS_W-1:0];
			REG_SPR_W:     cfg_w = value[SIZE_W-1:0];
			REG_SPR_H:     cfg_h = value[SIZE_W-1:0];
			REG_PPU:       cfg_ppu = value[PPU_W-1:0];
			REG_KEY_COLOR: cfg_key = value;
			default: ;
		endcase
	endtask

	task automatic test_reset_defaults();
		load_texel(0, 0, 32'hFFFF_FFFF);
		load_texel(63, 63, 32'h0000_0001);
		load_texel(0, 63, 32'h0000_0000);
		query_pixel(0, 0);
		query_pixel(63, 63);
		query_pixel(63, 0);
		query_pixel(64, 0);
		query_pixel(0, 64);
		query_pixel(5, 1023);
		query_pixel(1023, 767);
	endtask

	task automatic test_scale_extremes();
		// zero scale behaves as one texel per world unit
		apb_write(REG_PPU, '0);
		query_pixel(1023, 40);
		query_pixel(0, 767);
		apb_write(REG_PPU, 32'd255);
		query_pixel(7, 7);
		query_pixel(8, 0);
		apb_write(REG_PPU, 32'd32);
	endtask

	task automatic test_size_extremes();
		apb_write(REG_SPR_W, 32'd127);
		query_pixel(63, 10);
		query_pixel(64, 10);
		apb_write(REG_SPR_W, '0);
		query_pixel(0, 0);
		apb_write(REG_SPR_W, 32'd64);
		apb_write(REG_SPR_H, '0);
		query_pixel(0, 0);
		apb_write(REG_SPR_H, 32'd64);
	endtask

	task automatic test_position_extremes();
		apb_write(REG_POS_X, pos_word(-4096));
		query_pixel(0, 0);
		apb_write(REG_POS_X, pos_word(4095));
		query_pixel(1023, 0);
		apb_write(REG_POS_X, pos_word(-10));
		apb_write(REG_POS_Y, pos_word(700));
		query_pixel(0, 700);
		query_pixel(53, 763);
		query_pixel(53, 764);
	endtask

	task automatic test_key_and_unmapped();
		apb_write(REG_POS_X, '0);
		apb_write(REG_POS_Y, '0);
		apb_write(REG_KEY_COLOR, $urandom() | 32'h1);
		load_texel(2, 3, cfg_key);
		query_pixel(3, 2);
		apb_write(REG_UNMAPPED_LO, $urandom());
		apb_write(REG_UNMAPPED_HI, $urandom());
		query_pixel(3, 2);
		query_pixel(0, 0);
	endtask

	task automatic test_random_phases();
		int pick, ext_w, ext_h;
		for (int phase = 0; phase < PHASES; phase++) begin
			pick = $urandom_range(0, 9);
			apb_write(REG_PPU, (pick == 0) ? 0 : (pick == 1) ? 255 : (pick == 2) ? 1 :
				(pick < 6) ? $urandom_range(1, 255) : $urandom_range(16, 64));
			pick = $urandom_range(0, 9);
			apb_write(REG_SPR_W, (pick == 0) ? 0 : (pick == 1) ? 127 : (pick == 2) ?
				$urandom_range(65, 127) : (pick == 3) ? 64 : $urandom_range(1, 64));
			pick = $urandom_range(0, 9);
			apb_write(REG_SPR_H, (pick == 0) ? 0 : (pick == 1) ? 127 : (pick == 2) ?
				$urandom_range(65, 127) : (pick == 3) ? 64 : $urandom_range(1, 64));
			apb_write(REG_KEY_COLOR, $urandom());
			ext_w = draw_extent(cfg_w);
			ext_h = draw_extent(cfg_h);
			pick = $urandom_range(0, 9);
			apb_write(REG_POS_X, pos_word((pick == 0) ? -4096 : (pick == 1) ? 4095 :
				(pick == 2) ? int'($urandom_range(0, 8191)) - 4096 :
				int'($urandom_range(0, 1023 + ext_w)) - ext_w));
			pick = $urandom_range(0, 9);
			apb_write(REG_POS_Y, pos_word((pick == 0) ? -4096 : (pick == 1) ? 4095 :
				(pick == 2) ? int'($urandom_range(0, 8191)) - 4096 :
				int'($urandom_range(0, 767 + ext_h)) - ext_h));

			gaps_on = (phase != 0) && ($urandom_range(0, 3) != 0);
			rx_mode = (phase == 0) ? RX_OPEN : rx_mode_t'($urandom_range(0, 2));

			for (int n = 0; n < PHASE_BEATS; n++) begin
				pick = $urandom_range(0, 99);
				if (pick < 20)
					load_texel($urandom_range(0, SPRITE_MAX - 1), $urandom_range(0, SPRITE_MAX - 1),
						(pick < 3) ? cfg_key : $urandom());
				else if (pick < 85)
					query_pixel(pick_on_axis(cfg_pos_x, ext_w, SCREEN_W - 1),
						pick_on_axis(cfg_pos_y, ext_h, SCREEN_H - 1));
				else
					query_pixel($urandom_range(0, 1023), $urandom_range(0, 1023));
			end
		end
	endtask

	// receiver stall pattern
	always @(posedge clk) begin
		case (rx_mode)
			RX_OPEN:   result_ready <= 1'b1;
			RX_RANDOM: result_ready <= ($urandom_range(0, 3) != 0);
			default: begin
				if (rx_run > 0) begin
					rx_run--;
				end else begin
					result_ready <= !result_ready;
					rx_run = result_ready ? $urandom_range(1, 12) : $urandom_range(1, 6);
				end
			end
		endcase
	end

	always @(posedge clk) begin : check_results
		sss_out_t want;
		if (arst_n && result_valid && result_ready) begin
			if (pending_pixels.size() == 0) begin
				$error("result beat with no expected pixel: %h", result);
				errors++;
			end else begin
				want = pending_pixels.pop_front();
				if (result.write_enable !== want.write_enable) begin
					$error("write_enable: expected %0b, got %0b", want.write_enable,
						result.write_enable);
					errors++;
				end
				if (result.out_x !== want.out_x) begin
					$error("out_x: expected %0d, got %0d", want.out_x, result.out_x);
					errors++;
				end
				if (result.out_y !== want.out_y) begin
					$error("out_y: expected %0d, got %0d", want.out_y, result.out_y);
					errors++;
				end
				if (result.out_color !== want.out_color) begin
					$error("out_color: expected %h, got %h", want.out_color, result.out_color);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		arst_n       <= 1'b0;
		item_valid   <= 1'b0;
		item         <= '0;
		result_ready <= 1'b0;
		psel         <= 1'b0;
		penable      <= 1'b0;
		pwrite       <= 1'b0;
		paddr        <= '0;
		pwdata       <= '0;
		cfg_pos_x  = '0;
		cfg_pos_y  = '0;
		cfg_w      = SIZE_W'(SIZE_RESET);
		cfg_h      = SIZE_W'(SIZE_RESET);
		cfg_ppu    = PPU_W'(PPU_RESET);
		cfg_key    = '0;
		errors     = 0;
		cycle_count = 0;
		burst_left = 0;
		rx_run     = 0;
		gaps_on    = 1'b1;
		rx_mode    = RX_RANDOM;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_scale_extremes();
		test_size_extremes();
		test_position_extremes();
		test_key_and_unmapped();
		test_random_phases();

		item_valid <= 1'b0;
		while (pending_pixels.size() != 0) @(posedge clk);
		repeat (16) @(posedge clk);
		if (errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
